// ===== rtl/wepq_pkg.sv =====
`default_nettype none

package wepq_pkg;

  // Field widths fixed by the interface.
  localparam int WHEEL_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Default number of wheel channels that hold state.
  localparam int WHEEL_COUNT_DEFAULT = 4;

  // Register values after reset.
  localparam logic [31:0] DEBOUNCE_CYCLES_RESET       = 32'd8400;
  localparam logic [15:0] FLOOD_WINDOW_MS_RESET       = 16'd1000;
  localparam logic [9:0]  MAX_PULSES_PER_WINDOW_RESET = 10'd200;
  localparam logic [15:0] MIN_PULSE_INTERVAL_MS_RESET = 16'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_CYCLES       = 2'd0,
    REG_FLOOD_WINDOW_MS       = 2'd1,
    REG_MAX_PULSES_PER_WINDOW = 2'd2,
    REG_MIN_PULSE_INTERVAL_MS = 2'd3
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DEBOUNCED   = 3'd0,
    ST_RAW_FLOOD   = 3'd1,
    ST_HALF        = 3'd2,
    ST_INTERVAL    = 3'd3,
    ST_PULSE_FLOOD = 3'd4,
    ST_COUNTED     = 3'd5,
    ST_BAD_INDEX   = 3'd6
  } status_t;

  // Current register settings.
  typedef struct packed {
    logic [31:0] debounce_cycles;
    logic [15:0] flood_window_ms;
    logic [9:0]  max_pulses_per_window;
    logic [15:0] min_pulse_interval_ms;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [31:0]        cycle_stamp;
    logic [31:0]        ms_stamp;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel_echo;
    status_t            status;
    logic [31:0]        pulse_count;
    logic [31:0]        filtered_count;
    logic [31:0]        raw_transition_count;
    logic [31:0]        pulse_period_ms;
  } result_t;

  // State kept for each wheel channel.
  typedef struct packed {
    logic [31:0] last_edge_cycle;
    logic [31:0] filtered_counter;
    logic [31:0] raw_edge_counter;
    logic        half_cycle_flag;
    logic [31:0] raw_window_start;
    logic [10:0] raw_window_count;
    logic [31:0] last_pulse_tick;
    logic [31:0] prev_pulse_tick;
    logic [31:0] pulse_window_start;
    logic [9:0]  pulse_window_count;
    logic [31:0] pulse_counter;
  } wheel_state_t;

endpackage

`default_nettype wire

// ===== rtl/wepq_cfg.sv =====
`default_nettype none

module wepq_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [wepq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wepq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output wepq_pkg::cfg_t                        cfg
);
  import wepq_pkg::*;

  // Writes are always taken; software is to write only while the block is idle, and the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Register file with reset defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_cycles       <= DEBOUNCE_CYCLES_RESET;
      cfg.flood_window_ms       <= FLOOD_WINDOW_MS_RESET;
      cfg.max_pulses_per_window <= MAX_PULSES_PER_WINDOW_RESET;
      cfg.min_pulse_interval_ms <= MIN_PULSE_INTERVAL_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_CYCLES:       cfg.debounce_cycles       <= cfg_data;
        REG_FLOOD_WINDOW_MS:       cfg.flood_window_ms       <= cfg_data[15:0];
        REG_MAX_PULSES_PER_WINDOW: cfg.max_pulses_per_window <= cfg_data[9:0];
        REG_MIN_PULSE_INTERVAL_MS: cfg.min_pulse_interval_ms <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wepq_proc.sv =====
`default_nettype none

module wepq_proc (
  input  wire wepq_pkg::item_t        item,
  input  wire logic                   wheel_ok,
  input  wire wepq_pkg::cfg_t         cfg,
  input  wire wepq_pkg::wheel_state_t st,
  output wepq_pkg::wheel_state_t      st_next,
  output wepq_pkg::result_t           result
);
  import wepq_pkg::*;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
  endfunction

  logic [31:0] cyc;
  logic [31:0] now;
  logic [31:0] window;
  logic [10:0] raw_limit;
  logic        debounced;
  logic        raw_restart;
  logic        pulse_restart;
  logic        too_soon;
  logic [10:0] raw_count_cur;
  logic [9:0]  pulse_count_cur;
  status_t     status;

  assign cyc       = item.cycle_stamp;
  assign now       = item.ms_stamp;
  assign window    = {16'd0, cfg.flood_window_ms};
  assign raw_limit = {cfg.max_pulses_per_window, 1'b0};

  // All timestamp tests are evaluated side by side from the old state.
  assign debounced     = (cyc - st.last_edge_cycle) < cfg.debounce_cycles;
  assign raw_restart   = (now - st.raw_window_start) >= window;
  assign pulse_restart = (now - st.pulse_window_start) >= window;
  assign too_soon      = (now - st.last_pulse_tick) < {16'd0, cfg.min_pulse_interval_ms};

  assign raw_count_cur   = raw_restart   ? 11'd0 : st.raw_window_count;
  assign pulse_count_cur = pulse_restart ? 10'd0 : st.pulse_window_count;

  // Qualification chain: debounce, raw ceiling, pairing, interval, pulse ceiling.
  always_comb begin
    st_next = st;
    status  = ST_DEBOUNCED;
    if (debounced) begin
      st_next.filtered_counter = sat_inc(st.filtered_counter);
      status = ST_DEBOUNCED;
    end else begin
      st_next.last_edge_cycle  = cyc;
      st_next.raw_edge_counter = sat_inc(st.raw_edge_counter);
      if (raw_restart) begin
        st_next.raw_window_start = now;
      end
      st_next.raw_window_count = raw_count_cur;
      if (raw_count_cur >= raw_limit) begin
        st_next.filtered_counter = sat_inc(st.filtered_counter);
        status = ST_RAW_FLOOD;
      end else begin
        st_next.raw_window_count = raw_count_cur + 11'd1;
        st_next.half_cycle_flag  = ~st.half_cycle_flag;
        if (!st.half_cycle_flag) begin
          status = ST_HALF;
        end else if (too_soon) begin
          status = ST_INTERVAL;
        end else begin
          if (pulse_restart) begin
            st_next.pulse_window_start = now;
          end
          st_next.pulse_window_count = pulse_count_cur;
          if (pulse_count_cur >= cfg.max_pulses_per_window) begin
            status = ST_PULSE_FLOOD;
          end else begin
            st_next.pulse_counter      = sat_inc(st.pulse_counter);
            st_next.pulse_window_count = pulse_count_cur + 10'd1;
            st_next.prev_pulse_tick    = st.last_pulse_tick;
            st_next.last_pulse_tick    = now;
            status = ST_COUNTED;
          end
        end
      end
    end
  end

  // Result beat reports the updated counters; a bad wheel index reports zeros.
  always_comb begin
    result.wheel_echo = item.wheel;
    if (wheel_ok) begin
      result.status               = status;
      result.pulse_count          = st_next.pulse_counter;
      result.filtered_count       = st_next.filtered_counter;
      result.raw_transition_count = st_next.raw_edge_counter;
      result.pulse_period_ms      = st_next.last_pulse_tick - st_next.prev_pulse_tick;
    end else begin
      result.status               = ST_BAD_INDEX;
      result.pulse_count          = 32'd0;
      result.filtered_count       = 32'd0;
      result.raw_transition_count = 32'd0;
      result.pulse_period_ms      = 32'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wheel_edge_pair_pulse_qualifier_unit.sv =====
`default_nettype none

// Channel   Signals                               Direction
// item      item_valid, item_stall, item          edge events in
// result    result_valid, result_stall, result    qualified results out
// cfg       cfg_valid, cfg_ready, cfg_index/data  register writes in
//
// One result per item. An item is registered, then qualified combinationally
// against its wheel's state, which is updated in the same cycle the result
// register loads; one item is taken every cycle unless the result register is blocked.
// Synchronous reset restores register defaults and clears all wheel state.
// The result register holds while it is full and result_stall is high; item_stall rises
// only when the input register is occupied and the full result register is stalled.

module wheel_edge_pair_pulse_qualifier_unit #(
  parameter int WHEEL_COUNT = wepq_pkg::WHEEL_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire wepq_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output wepq_pkg::result_t                     result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [wepq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wepq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wepq_pkg::*;

  localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  cfg_t         cfg;
  logic         s1_valid;
  item_t        s1_item;
  logic         load_out;
  logic         advance;
  logic         wheel_ok;
  logic [IDX_W-1:0] wheel_idx;
  wheel_state_t state [WHEEL_COUNT];
  wheel_state_t st_cur;
  wheel_state_t st_next;
  result_t      result_next;

  wepq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the result register frees up when empty or being taken.
  assign load_out   = !result_valid || !result_stall;
  assign item_stall = s1_valid && !load_out;
  assign advance    = s1_valid && load_out;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // Wheel selection and state read.
  assign wheel_ok  = {1'b0, s1_item.wheel} < 3'(WHEEL_COUNT);
  assign wheel_idx = s1_item.wheel[IDX_W-1:0];
  assign st_cur    = state[wheel_idx];

  wepq_proc u_proc (
    .item     (s1_item),
    .wheel_ok (wheel_ok),
    .cfg      (cfg),
    .st       (st_cur),
    .st_next  (st_next),
    .result   (result_next)
  );

  // Per-wheel state, written back as each beat with a valid wheel index moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        state[i] <= '0;
      end
    end else if (advance && wheel_ok) begin
      state[wheel_idx] <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  // Input back-pressure only comes from a blocked result register.
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("item_stall without a blocked result");

  // A counted pulse always shows a nonzero pulse count.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_COUNTED) |-> (result.pulse_count != 32'd0))
    else $error("counted pulse with zero pulse count");

  // A bad wheel index reports zeros.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_BAD_INDEX) |->
      (result.pulse_count == 32'd0 && result.filtered_count == 32'd0 &&
       result.raw_transition_count == 32'd0 && result.pulse_period_ms == 32'd0))
    else $error("bad index result carries counts");

  // A taken result with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !s1_valid) |=> !result_valid)
    else $error("result repeated after being taken");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_wheel_edge_pair_pulse_qualifier_unit.sv =====
`timescale 1ns / 1ps

module tb_wheel_edge_pair_pulse_qualifier_unit;
  import wepq_pkg::*;

  localparam int WHEEL_SLOTS = WHEEL_COUNT_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 8;
  localparam int EDGES_PER_PHASE = 150;

  // Tracks every wheel's counters and windows and queues the result each edge should give.
  class wheel_pulse_tracker;
    logic [31:0] debounce;
    logic [15:0] window;
    logic [9:0]  pulse_cap;
    logic [15:0] min_gap;

    logic [31:0] last_edge_cyc[WHEEL_SLOTS];
    logic [31:0] filtered[WHEEL_SLOTS];
    logic [31:0] raw_edges[WHEEL_SLOTS];
    logic        half[WHEEL_SLOTS];
    logic [31:0] raw_win_start[WHEEL_SLOTS];
    logic [10:0] raw_win_cnt[WHEEL_SLOTS];
    logic [31:0] last_pulse[WHEEL_SLOTS];
    logic [31:0] prev_pulse[WHEEL_SLOTS];
    logic [31:0] pulse_win_start[WHEEL_SLOTS];
    logic [9:0]  pulse_win_cnt[WHEEL_SLOTS];
    logic [31:0] pulses[WHEEL_SLOTS];

    result_t expected_results[$];
    int mismatches;

    function new();
      debounce = DEBOUNCE_CYCLES_RESET;
      window = FLOOD_WINDOW_MS_RESET;
      pulse_cap = MAX_PULSES_PER_WINDOW_RESET;
      min_gap = MIN_PULSE_INTERVAL_MS_RESET;
      mismatches = 0;
      for (int i = 0; i < WHEEL_SLOTS; i++) begin
        last_edge_cyc[i] = '0;
        filtered[i] = '0;
        raw_edges[i] = '0;
        half[i] = 1'b0;
        raw_win_start[i] = '0;
        raw_win_cnt[i] = '0;
        last_pulse[i] = '0;
        prev_pulse[i] = '0;
        pulse_win_start[i] = '0;
        pulse_win_cnt[i] = '0;
        pulses[i] = '0;
      end
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_DEBOUNCE_CYCLES:       debounce = data;
        REG_FLOOD_WINDOW_MS:       window = data[15:0];
        REG_MAX_PULSES_PER_WINDOW: pulse_cap = data[9:0];
        REG_MIN_PULSE_INTERVAL_MS: min_gap = data[15:0];
        default: ;
      endcase
    endfunction

    // Qualify one accepted edge against its wheel's state.
    function void note_edge(item_t it);
      result_t r;
      logic [1:0] w;
      logic [31:0] cyc;
      logic [31:0] now;
      logic [31:0] raw_limit;
      status_t st;
      w = it.wheel;
      cyc = it.cycle_stamp;
      now = it.ms_stamp;
      r = '0;
      r.wheel_echo = w;
      if (int'(w) >= WHEEL_SLOTS) begin
        r.status = ST_BAD_INDEX;
      end else begin
        raw_limit = {21'd0, pulse_cap, 1'b0};
        if (cyc - last_edge_cyc[w] < debounce) begin
          filtered[w] = bump(filtered[w]);
          st = ST_DEBOUNCED;
        end else begin
          last_edge_cyc[w] = cyc;
          raw_edges[w] = bump(raw_edges[w]);
          if (now - raw_win_start[w] >= {16'd0, window}) begin
            raw_win_start[w] = now;
            raw_win_cnt[w] = '0;
          end
          if ({21'd0, raw_win_cnt[w]} >= raw_limit) begin
            filtered[w] = bump(filtered[w]);
            st = ST_RAW_FLOOD;
          end else begin
            raw_win_cnt[w] = raw_win_cnt[w] + 11'd1;
            // Edges that clear the raw ceiling alternate between opening and completing a pair.
            half[w] = ~half[w];
            if (half[w]) begin
              st = ST_HALF;
            end else if (now - last_pulse[w] < {16'd0, min_gap}) begin
              st = ST_INTERVAL;
            end else begin
              // The pulse window restarts even when this pulse then floods.
              if (now - pulse_win_start[w] >= {16'd0, window}) begin
                pulse_win_start[w] = now;
                pulse_win_cnt[w] = '0;
              end
              if (pulse_win_cnt[w] >= pulse_cap) begin
                st = ST_PULSE_FLOOD;
              end else begin
                pulses[w] = bump(pulses[w]);
                pulse_win_cnt[w] = pulse_win_cnt[w] + 10'd1;
                prev_pulse[w] = last_pulse[w];
                last_pulse[w] = now;
                st = ST_COUNTED;
              end
            end
          end
        end
        r.status = st;
        r.pulse_count = pulses[w];
        r.filtered_count = filtered[w];
        r.raw_transition_count = raw_edges[w];
        r.pulse_period_ms = last_pulse[w] - prev_pulse[w];
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("wheel_echo", 32'(want.wheel_echo), 32'(got.wheel_echo));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("pulse_count", want.pulse_count, got.pulse_count);
      compare_field("filtered_count", want.filtered_count, got.filtered_count);
      compare_field("raw_transition_count", want.raw_transition_count,
                    got.raw_transition_count);
      compare_field("pulse_period_ms", want.pulse_period_ms, got.pulse_period_ms);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wheel_pulse_tracker tracker;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int holds_asked = 0;

  // Stimulus-side view of the timing registers and each wheel's clocks.
  logic [31:0] cur_debounce = DEBOUNCE_CYCLES_RESET;
  logic [31:0] cur_window = 32'(FLOOD_WINDOW_MS_RESET);
  logic [31:0] cur_min_int = 32'(MIN_PULSE_INTERVAL_MS_RESET);
  logic [31:0] cyc_now[WHEEL_SLOTS];
  logic [31:0] ms_now[WHEEL_SLOTS];

  wheel_edge_pair_pulse_qualifier_unit uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst == 1'b0) begin
      if (item_valid && !item_stall) begin
        tracker.note_edge(item);
      end
      if (result_valid && !result_stall) begin
        tracker.check_result(result);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int holds_done;
    holds_done = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        result_stall = 1'b1;
        for (int k = 1; k < LONG_HOLD; k++) begin
          @(negedge clk);
        end
      end else begin
        result_stall = (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Offer one beat, after a random gap, and hold it until it is taken.
  task send_edge(input item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (item_stall);
  endtask

  task send_at(input logic [1:0] w, input logic [31:0] cyc, input logic [31:0] ms);
    item_t it;
    it.wheel = w;
    it.cycle_stamp = cyc;
    it.ms_stamp = ms;
    send_edge(it);
  endtask

  // Let every pending result come out before touching the registers.
  task wait_idle();
    @(negedge clk);
    item_valid = 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    case (idx)
      REG_DEBOUNCE_CYCLES:       cur_debounce = data;
      REG_FLOOD_WINDOW_MS:       cur_window = {16'd0, data[15:0]};
      REG_MIN_PULSE_INTERVAL_MS: cur_min_int = {16'd0, data[15:0]};
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task configure(input logic [31:0] deb, input logic [31:0] win,
                 input logic [31:0] cap, input logic [31:0] gap_ms);
    wait_idle();
    write_reg(REG_DEBOUNCE_CYCLES, deb);
    write_reg(REG_FLOOD_WINDOW_MS, win);
    write_reg(REG_MAX_PULSES_PER_WINDOW, cap);
    write_reg(REG_MIN_PULSE_INTERVAL_MS, gap_ms);
  endtask

  // Mostly edges that clear debounce with small millisecond steps, so pairs,
  // intervals and both ceilings come into play; some short gaps and wild stamps.
  function automatic item_t next_edge();
    item_t it;
    logic [1:0] w;
    int pick;
    w = 2'($urandom_range(0, WHEEL_SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cyc_now[w] = cyc_now[w] + cur_debounce + $urandom_range(0, 3);
    end else if (pick < 70) begin
      cyc_now[w] = cyc_now[w] + cur_debounce + $urandom_range(0, 5000);
    end else if (pick < 90) begin
      cyc_now[w] = cyc_now[w] + $urandom_range(0, cur_debounce);
    end else begin
      cyc_now[w] = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      ms_now[w] = ms_now[w] + $urandom_range(0, 3);
    end else if (pick < 75) begin
      ms_now[w] = ms_now[w] + $urandom_range(0, cur_min_int + 2);
    end else if (pick < 90) begin
      ms_now[w] = ms_now[w] + $urandom_range(0, cur_window);
    end else if (pick < 95) begin
      ms_now[w] = ms_now[w] + cur_window + $urandom_range(0, 3);
    end else begin
      ms_now[w] = $urandom;
    end
    it.wheel = w;
    it.cycle_stamp = cyc_now[w];
    it.ms_stamp = ms_now[w];
    return it;
  endfunction

  initial begin
    int p;
    int n;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < WHEEL_SLOTS; i++) begin
      cyc_now[i] = '0;
      ms_now[i] = '0;
    end
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed edges under the reset settings: debounce at and below the gap,
    // pairing, a too-early pulse, a counted pulse and wrapping stamps.
    send_at(2'd0, 32'd0, 32'd0);
    send_at(2'd0, 32'd8400, 32'd0);
    send_at(2'd0, 32'd16800, 32'd1);
    send_at(2'd0, 32'd25200, 32'd2);
    send_at(2'd0, 32'd33600, 32'd5);
    send_at(2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_at(2'd1, 32'h0000_20CF, 32'h0000_0004);
    send_at(2'd2, 32'd8399, 32'd7);
    send_at(2'd3, 32'd8400, 32'hFFFF_FFFF);
    send_at(2'd3, 32'h8000_0000, 32'hFFFF_FFFF);

    // A zero pulse ceiling makes every edge that clears debounce a raw flood.
    wait_idle();
    write_reg(REG_MAX_PULSES_PER_WINDOW, 32'd0);
    send_at(2'd2, 32'd100000, 32'd10);
    send_at(2'd2, 32'd200000, 32'd11);

    // A zero window restarts each window whenever an edge reaches its check.
    wait_idle();
    write_reg(REG_FLOOD_WINDOW_MS, 32'd0);
    write_reg(REG_MAX_PULSES_PER_WINDOW, 32'd1);
    send_at(2'd2, 32'd300000, 32'd20);
    send_at(2'd2, 32'd400000, 32'd23);
    send_at(2'd2, 32'd500000, 32'd26);
    send_at(2'd2, 32'd600000, 32'd29);
    send_at(2'd2, 32'd700000, 32'd29);

    // Random phases, each with its register settings and one of four idling patterns.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(32'd100, 32'd20, 32'd2, 32'd1);
        1: configure(32'd0, 32'd1, 32'd1, 32'd0);
        2: configure(32'd5000, 32'd65535, 32'd1023, 32'd65535);
        3: configure(32'hFFFF_FFFF, 32'd100, 32'd3, 32'd2);
        4: configure(32'd300, 32'd50, 32'd4, 32'd5);
        5: configure($urandom_range(0, 2000), $urandom_range(1, 200),
                     $urandom_range(1, 8), $urandom_range(0, 10));
        6: configure(32'd8400, 32'd1000, 32'd200, 32'd2);
        default: configure($urandom_range(0, 20000), $urandom_range(1, 400),
                           $urandom_range(1, 16), $urandom_range(0, 20));
      endcase
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 76;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 76;
        end
        default: begin
          tx_idle_pct = 14;
          rx_stall_pct = 14;
        end
      endcase
      for (n = 0; n < EDGES_PER_PHASE; n++) begin
        // Hold the result side off while edges keep coming, so the input backs up.
        if (p == 4 && n == 40) begin
          holds_asked++;
        end
        send_edge(next_edge());
      end
    end

    wait_idle();
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
